// ===== rtl/pkf_pkg.sv =====
// Package for the PID controller with derivative spike filter.
// Holds fixed-point widths, register and microcode encodings, and the control store.
// No dependencies.
package pkf_pkg;

    // Fixed-point format and derived widths
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int MUL_W     = DATA_W + 1;         // operand width incl. unsigned magnitude
    localparam int PROD_W    = 2 * MUL_W;
    localparam int PW        = 2 * DATA_W - FRAC_BITS; // scaled product width
    localparam int IW        = PW + 1;             // integral update sum
    localparam int SW        = PW + 2;             // P + I - D sum

    // n / 100 as (n * RECIP_100) >> RECIP_SHIFT, exact for any 32-bit unsigned n
    localparam logic [MUL_W-1:0] RECIP_100 = MUL_W'(64'd1374389535);
    localparam int RECIP_SHIFT = 37;
    localparam int QW          = PROD_W - RECIP_SHIFT;

    // Configuration register map
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_KP     = 3'd0;
    localparam logic [2:0] REG_KI     = 3'd1;
    localparam logic [2:0] REG_KD     = 3'd2;
    localparam logic [2:0] REG_MIN    = 3'd3;
    localparam logic [2:0] REG_MAX    = 3'd4;
    localparam logic [2:0] REG_FILTER = 3'd5;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Multiplier operand selection
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_KP,
        MUL_KI,
        MUL_REC,
        MUL_KD
    } t_mul_sel;

    // What the step does with the registered product
    typedef enum logic [2:0] {
        WB_NONE,
        WB_P,
        WB_INTEG,
        WB_CHG,
        WB_SUM,
        WB_OUT
    } t_wb_sel;

    typedef enum logic {
        JMP_NEXT,
        JMP_NOSPIKE
    } t_jmp;

    localparam int STEP_W = 3;

    typedef struct packed {
        t_mul_sel          mul_sel;
        t_wb_sel           wb_sel;
        t_jmp              jmp;
        logic [STEP_W-1:0] target;
        logic              last;
    } t_uword;

    // Control store: one word per step
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '{mul_sel: MUL_NONE, wb_sel: WB_NONE, jmp: JMP_NEXT, target: '0, last: 1'b0};
        case (step)
            3'd0: w.mul_sel = MUL_KP;
            3'd1: begin
                w.mul_sel = MUL_KI;
                w.wb_sel  = WB_P;
            end
            3'd2: begin
                w.mul_sel = MUL_REC;
                w.wb_sel  = WB_INTEG;
                w.jmp     = JMP_NOSPIKE;
                w.target  = 3'd4;
            end
            3'd3: w.wb_sel = WB_CHG;
            3'd4: w.mul_sel = MUL_KD;
            3'd5: w.wb_sel = WB_SUM;
            3'd6: begin
                w.wb_sel = WB_OUT;
                w.last   = 1'b1;
            end
            default: w.last = 1'b1;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/pkf_mul.sv =====
// Shared signed multiplier with registered product.
// Depends on pkf_pkg for operand and product widths.
module pkf_mul
    import pkf_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_op_a,
    input  logic signed [MUL_W-1:0]  i_op_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    // one product per cycle, result in the next cycle
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_op_a) * PROD_W'(i_op_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/pid_controller_kick_filter.sv =====
// PID controller step, Q16.16, derivative on measurement with spike filter.
// Depends on pkf_pkg and pkf_mul.
//
// Usage:
//  - Input stream s_axis: tdata = {measurement, setpoint}, tuser = command
//    (0 compute step, 1 reset command). A word is taken when tvalid and tready
//    are both high; tready is high only while the controller is idle.
//  - Output stream m_axis: tdata = drive, one word per compute step, none for
//    a reset command. The output register holds the word until tready.
//  - APB port: gains, limits and filter enable at byte addresses 0,4,..,20.
//    Write only while idle; reads return the stored value; pready is tied high.
//  - A compute step runs a 7-step microprogram on one shared 33x33 multiplier
//    (6 steps when the spike filter does not fire). The next input word is
//    taken only after the result is loaded into the output register, so one
//    item is in flight at a time.
//  - If the previous result has not been taken, the last step waits for the
//    output register to free up.
//  - i_rst_n (synchronous) clears registers to their defaults, the integral
//    and last measurement to zero, and the output to empty.
module pid_controller_kick_filter
    import pkf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [63:0]       s_axis_tdata,  // [31:0] setpoint, [63:32] measurement
    input  logic              s_axis_tuser,  // [0] command
    // output stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,  // [31:0] drive
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // ---------------- configuration registers ----------------
    logic signed [DATA_W-1:0] r_kp, r_ki, r_kd, r_out_min, r_out_max;
    logic                     r_filter_on;
    logic [2:0]               cfg_idx;

    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp        <= '0;
            r_ki        <= '0;
            r_kd        <= '0;
            r_out_min   <= {1'b1, {(DATA_W-1){1'b0}}};
            r_out_max   <= {1'b0, {(DATA_W-1){1'b1}}};
            r_filter_on <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (cfg_idx)
                REG_KP:     r_kp        <= pwdata;
                REG_KI:     r_ki        <= pwdata;
                REG_KD:     r_kd        <= pwdata;
                REG_MIN:    r_out_min   <= pwdata;
                REG_MAX:    r_out_max   <= pwdata;
                REG_FILTER: r_filter_on <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (cfg_idx)
            REG_KP:     prdata = r_kp;
            REG_KI:     prdata = r_ki;
            REG_KD:     prdata = r_kd;
            REG_MIN:    prdata = r_out_min;
            REG_MAX:    prdata = r_out_max;
            REG_FILTER: prdata = {31'd0, r_filter_on};
            default:    prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    t_uword            uw;
    logic              spike;
    logic              out_free;
    logic              in_take;
    logic              step_adv;

    assign uw            = ucode(r_step);
    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign step_adv      = (r_state == ST_RUN) && (!uw.last || out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (in_take && !s_axis_tuser) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (step_adv) begin
                    if (uw.last) begin
                        n_state = ST_IDLE;
                        n_step  = '0;
                    end else if (uw.jmp == JMP_NOSPIKE && !spike) begin
                        n_step = uw.target;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- datapath ----------------
    logic signed [DATA_W-1:0]   r_err, r_meas, r_prev, r_integral;
    logic signed [DATA_W:0]     r_chg;     // raw change, 33 bits
    logic signed [PW-1:0]       r_p;
    logic signed [SW-1:0]       r_sum;
    logic                       r_skip;
    logic [DATA_W-1:0]          r_out;
    logic                       r_out_valid;

    logic signed [DATA_W-1:0]   in_sp, in_meas;
    logic signed [DATA_W:0]     diff_err, diff_chg;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PW-1:0]       prod_shr;
    logic [QW-1:0]              quot;
    logic [DATA_W-1:0]          prev_mag;
    logic [DATA_W:0]            chg_mag;
    logic signed [DATA_W-1:0]   chg_sat;
    logic signed [MUL_W-1:0]    op_a, op_b;
    logic signed [IW-1:0]       integ_sum;
    logic signed [SW-1:0]       drive_sum;

    function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
        if (v[DATA_W] != v[DATA_W-1]) begin
            return v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return v[DATA_W-1:0];
    endfunction

    // upper limit first, then lower
    function automatic logic signed [DATA_W-1:0] clamp_lim(
        input logic signed [SW-1:0]     v,
        input logic signed [DATA_W-1:0] lo,
        input logic signed [DATA_W-1:0] hi
    );
        logic signed [SW-1:0] lo_x, hi_x, t;
        lo_x = {{(SW-DATA_W){lo[DATA_W-1]}}, lo};
        hi_x = {{(SW-DATA_W){hi[DATA_W-1]}}, hi};
        t = v;
        if (t > hi_x) t = hi_x;
        if (t < lo_x) t = lo_x;
        return t[DATA_W-1:0];
    endfunction

    assign in_sp    = s_axis_tdata[31:0];
    assign in_meas  = s_axis_tdata[63:32];
    assign diff_err = {in_sp[DATA_W-1], in_sp} - {in_meas[DATA_W-1], in_meas};
    assign diff_chg = {in_meas[DATA_W-1], in_meas} - {r_prev[DATA_W-1], r_prev};

    assign prod_shr = prod[2*DATA_W-1:FRAC_BITS];
    assign quot     = prod[PROD_W-1:RECIP_SHIFT];
    assign prev_mag = r_prev[DATA_W-1] ? DATA_W'(-r_prev) : DATA_W'(r_prev);
    assign chg_mag  = r_chg[DATA_W] ? (DATA_W+1)'(-r_chg) : (DATA_W+1)'(r_chg);
    assign chg_sat  = sat33(r_chg);
    assign spike    = r_filter_on &&
                      ({chg_mag, 2'b00} >= {{3{1'b0}}, prev_mag});

    assign integ_sum = {{(IW-DATA_W){r_integral[DATA_W-1]}}, r_integral}
                     + {prod_shr[PW-1], prod_shr};
    assign drive_sum = {{(SW-PW){r_p[PW-1]}}, r_p}
                     + {{(SW-DATA_W){r_integral[DATA_W-1]}}, r_integral}
                     - {{(SW-PW){prod_shr[PW-1]}}, prod_shr};

    // multiplier operands per control word
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (uw.mul_sel)
            MUL_KP: begin
                op_a = {r_kp[DATA_W-1], r_kp};
                op_b = {r_err[DATA_W-1], r_err};
            end
            MUL_KI: begin
                op_a = {r_ki[DATA_W-1], r_ki};
                op_b = {r_err[DATA_W-1], r_err};
            end
            MUL_REC: begin
                op_a = {1'b0, prev_mag};
                op_b = RECIP_100;
            end
            MUL_KD: begin
                op_a = {r_kd[DATA_W-1], r_kd};
                op_b = r_skip ? '0 : {chg_sat[DATA_W-1], chg_sat};
            end
            default: ;
        endcase
    end

    pkf_mul u_mul (
        .i_clk  (i_clk),
        .i_op_a (op_a),
        .i_op_b (op_b),
        .o_prod (prod)
    );

    // loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_prev     <= '0;
            r_skip     <= 1'b0;
        end else if (in_take && s_axis_tuser) begin
            r_integral <= '0;
            r_prev     <= '0;
            r_skip     <= 1'b1;
        end else if (r_state == ST_RUN) begin
            if (uw.wb_sel == WB_INTEG) begin
                r_integral <= clamp_lim({integ_sum[IW-1], integ_sum}, r_out_min, r_out_max);
            end
            if (uw.wb_sel == WB_OUT && out_free) begin
                r_prev <= r_meas;
                r_skip <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (in_take && !s_axis_tuser) begin
            r_err  <= sat33(diff_err);
            r_chg  <= diff_chg;
            r_meas <= in_meas;
        end else if (r_state == ST_RUN && uw.wb_sel == WB_CHG) begin
            r_chg <= r_chg[DATA_W] ? -(DATA_W+1)'(quot) : (DATA_W+1)'(quot);
        end
        if (r_state == ST_RUN && uw.wb_sel == WB_P) begin
            r_p <= prod_shr;
        end
        if (r_state == ST_RUN && uw.wb_sel == WB_SUM) begin
            r_sum <= drive_sum;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_RUN && uw.wb_sel == WB_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RUN && uw.wb_sel == WB_OUT && out_free) begin
            r_out <= clamp_lim(r_sum, r_out_min, r_out_max);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule
